// ===== design/bde_pkg.sv =====
// Shared opcodes, status codes and controller/datapath interface types for the deque engine.
`default_nettype none

package bde_pkg;

   localparam int unsigned OP_W     = 4;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned FILL_W   = 6;

   // Opcodes
   localparam logic [OP_W-1:0] OP_ADD_FRONT  = 4'd0;
   localparam logic [OP_W-1:0] OP_ADD_BACK   = 4'd1;
   localparam logic [OP_W-1:0] OP_DROP_FRONT = 4'd2;
   localparam logic [OP_W-1:0] OP_DROP_BACK  = 4'd3;
   localparam logic [OP_W-1:0] OP_REMOVE     = 4'd4;
   localparam logic [OP_W-1:0] OP_EMIT_ALL   = 4'd5;
   localparam logic [OP_W-1:0] OP_EMIT_FIRST = 4'd6;
   localparam logic [OP_W-1:0] OP_EMIT_LAST  = 4'd7;
   localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic take_item;    // latch opcode and argument
      logic decode;       // apply the direct update, set up walks
      logic scan_run;     // value-removal compaction walk
      logic emit_run;     // element emit walk
      logic send_status;  // load a status result when the output is free
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic go_scan;
      logic go_emit;
      logic walk_done;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== design/bde_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bde_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: hold data when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/bde_datapath.sv =====
// Datapath of the deque engine: ring pointers, entry RAM, walk counters and result register.
`default_nettype none

module bde_datapath #(
   parameter int unsigned CAPACITY = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bde_pkg::cmd_type                cmd,
   output bde_pkg::sts_type                     sts,
   input  wire logic [bde_pkg::OP_W-1:0]        req_opcode,
   input  wire logic signed [bde_pkg::DATA_W-1:0] req_argument,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [bde_pkg::DATA_W-1:0]    rsp_item_value,
   output logic                                 rsp_item_valid,
   output logic                                 rsp_last_of_run,
   output logic [bde_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bde_pkg::FILL_W-1:0]           rsp_fill_level
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned SUM_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   localparam int unsigned DW = bde_pkg::DATA_W;

   // Item and queue state
   logic [bde_pkg::OP_W-1:0]      op_ff, op_in;
   logic [DW-1:0]                 arg_ff, arg_in;
   logic [IDX_W-1:0]              front_ff, front_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              walk_ff, walk_in;
   logic [CNT_W-1:0]              limit_ff, limit_in;
   logic [CNT_W-1:0]              kept_ff, kept_in;
   logic                          pend_ff, pend_in;
   logic                          pend_last_ff, pend_last_in;
   logic [bde_pkg::STATUS_W-1:0]  status_ff, status_in;

   // Result register
   logic                          out_valid_ff, out_valid_in;
   logic [DW-1:0]                 out_value_ff, out_value_in;
   logic                          out_item_ff, out_item_in;
   logic                          out_last_ff, out_last_in;
   logic [bde_pkg::STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [bde_pkg::FILL_W-1:0]    out_fill_ff, out_fill_in;

   // RAM ports
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DW-1:0]     wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [DW-1:0]     rd_data;

   // Decode helpers
   logic              is_full;
   logic              is_empty;
   logic              is_emit;
   logic [CNT_W-1:0]  emit_n;
   logic [CNT_W-1:0]  emit_start;
   logic [IDX_W-1:0]  front_dec;
   logic              out_free;
   logic              move;
   logic              issue;
   logic              walk_more;

   // Ring position of the k-th entry from the front
   function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] front,
                                                 input logic [CNT_W-1:0] k);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(front) + SUM_W'(k);
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[IDX_W-1:0];
   endfunction

   bde_ram #(
      .WIDTH (DW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Decode-time helpers from the latched item
   always_comb begin
      is_full   = (count_ff == CAP_CNT);
      is_empty  = (count_ff == '0);
      is_emit   = (op_ff == bde_pkg::OP_EMIT_ALL) || (op_ff == bde_pkg::OP_EMIT_FIRST) ||
                  (op_ff == bde_pkg::OP_EMIT_LAST);
      front_dec = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
      // Clamp the count: negative acts as zero, above the fill level takes the fill level
      if (op_ff == bde_pkg::OP_EMIT_ALL) begin
         emit_n = count_ff;
      end else if (arg_ff[DW-1]) begin
         emit_n = '0;
      end else if (arg_ff > DW'(count_ff)) begin
         emit_n = count_ff;
      end else begin
         emit_n = arg_ff[CNT_W-1:0];
      end
      emit_start = (op_ff == bde_pkg::OP_EMIT_LAST) ? count_ff - emit_n : '0;
   end

   // Walk handshake with the result register
   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      walk_more = (walk_ff != limit_ff);
      move      = cmd.emit_run && pend_ff && out_free;
      issue     = (cmd.scan_run && walk_more) ||
                  (cmd.emit_run && walk_more && (!pend_ff || move));
   end

   always_comb begin
      sts.go_scan   = (op_ff == bde_pkg::OP_REMOVE) && !is_empty;
      sts.go_emit   = is_emit && (emit_n != '0);
      sts.walk_done = !walk_more && !pend_ff;
      sts.out_free  = out_free;
   end

   // Next-state logic
   always_comb begin
      op_in        = op_ff;
      arg_in       = arg_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      limit_in     = limit_ff;
      kept_in      = kept_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = ring_pos(front_ff, kept_ff);
      wr_data      = rd_data;
      rd_en        = issue;
      rd_addr      = ring_pos(front_ff, walk_ff);

      // Latch the accepted transfer
      if (cmd.take_item) begin
         op_in  = req_opcode;
         arg_in = req_argument;
      end

      // Direct updates and walk setup
      if (cmd.decode) begin
         status_in = bde_pkg::ST_OK;
         unique case (op_ff) inside
            bde_pkg::OP_ADD_FRONT: begin
               if (is_full) begin
                  status_in = bde_pkg::ST_FULL;
               end else begin
                  front_in = front_dec;
                  count_in = count_ff + CNT_W'(1);
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  wr_data  = arg_ff;
               end
            end
            bde_pkg::OP_ADD_BACK: begin
               if (is_full) begin
                  status_in = bde_pkg::ST_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  wr_en    = 1'b1;
                  wr_addr  = ring_pos(front_ff, count_ff);
                  wr_data  = arg_ff;
               end
            end
            bde_pkg::OP_DROP_FRONT: begin
               if (is_empty) begin
                  status_in = bde_pkg::ST_EMPTY;
               end else begin
                  front_in = ring_pos(front_ff, CNT_W'(1));
                  count_in = count_ff - CNT_W'(1);
               end
            end
            bde_pkg::OP_DROP_BACK: begin
               if (is_empty) begin
                  status_in = bde_pkg::ST_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            bde_pkg::OP_REMOVE: begin
               if (is_empty) begin
                  status_in = bde_pkg::ST_EMPTY;
               end else begin
                  walk_in  = '0;
                  limit_in = count_ff;
                  kept_in  = '0;
               end
            end
            bde_pkg::OP_EMIT_ALL, bde_pkg::OP_EMIT_FIRST, bde_pkg::OP_EMIT_LAST: begin
               walk_in  = emit_start;
               limit_in = emit_start + emit_n;
            end
            bde_pkg::OP_CLEAR: begin
               front_in = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end

      // Advance the read side of either walk
      if (issue) begin
         walk_in      = walk_ff + CNT_W'(1);
         pend_last_in = (walk_ff + CNT_W'(1) == limit_ff);
      end

      // Compaction: write back every entry that does not match
      if (cmd.scan_run) begin
         pend_in = issue;
         if (pend_ff && (rd_data != arg_ff)) begin
            wr_en   = 1'b1;
            kept_in = kept_ff + CNT_W'(1);
         end
         if (sts.walk_done) begin
            count_in = kept_ff;
         end
      end

      if (cmd.emit_run) begin
         pend_in = issue || (pend_ff && !move);
      end
   end

   // Result register
   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_value_in  = out_value_ff;
      out_item_in   = out_item_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_fill_in   = out_fill_ff;
      if (move) begin
         out_valid_in  = 1'b1;
         out_value_in  = rd_data;
         out_item_in   = 1'b1;
         out_last_in   = pend_last_ff;
         out_status_in = bde_pkg::ST_OK;
         out_fill_in   = bde_pkg::FILL_W'(count_ff);
      end else if (cmd.send_status && out_free) begin
         out_valid_in  = 1'b1;
         out_value_in  = '0;
         out_item_in   = 1'b0;
         out_last_in   = 1'b1;
         out_status_in = status_ff;
         out_fill_in   = bde_pkg::FILL_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         walk_ff      <= '0;
         limit_ff     <= '0;
         kept_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         limit_ff     <= limit_in;
         kept_ff      <= kept_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      arg_ff        <= arg_in;
      pend_last_ff  <= pend_last_in;
      status_ff     <= status_in;
      out_value_ff  <= out_value_in;
      out_item_ff   <= out_item_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      out_fill_ff   <= out_fill_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_item_value  = out_value_ff;
   assign rsp_item_valid  = out_item_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_fill_level  = out_fill_ff;

   // The queue never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   // A walk never runs past its end
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_run || cmd.emit_run) |-> walk_ff <= limit_ff)
      else $error("walk index past its limit");

   // Compaction writes never overtake the reads
   a_kept_behind: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_run |-> kept_ff <= walk_ff)
      else $error("compaction write ahead of read");

   // An element is only moved out when the read data is waiting
   a_move_pending: assert property (@(posedge clock) disable iff (reset)
      move |-> pend_ff && !cmd.scan_run)
      else $error("emit transfer without pending read data");

endmodule

`default_nettype wire

// ===== design/bde_ctrl.sv =====
// Controller state machine of the deque engine: sequences decode, walks and status replies.
`default_nettype none

module bde_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bde_pkg::sts_type sts,
   output bde_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      IDLE,
      DECODE,
      SCAN,
      EMIT,
      REPLY
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               state_in = DECODE;
            end
         end
         DECODE: begin
            if (sts.go_scan) begin
               state_in = SCAN;
            end else if (sts.go_emit) begin
               state_in = EMIT;
            end else begin
               state_in = REPLY;
            end
         end
         SCAN: begin
            if (sts.walk_done) begin
               state_in = REPLY;
            end
         end
         EMIT: begin
            if (sts.walk_done) begin
               state_in = IDLE;
            end
         end
         REPLY: begin
            if (sts.out_free) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      stall_in = (state_in != IDLE);
   end

   // Hold state and the registered stall
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   // Commands decoded from state
   always_comb begin
      cmd.take_item   = (state_ff == IDLE) && req_valid;
      cmd.decode      = (state_ff == DECODE);
      cmd.scan_run    = (state_ff == SCAN);
      cmd.emit_run    = (state_ff == EMIT);
      cmd.send_status = (state_ff == REPLY);
   end

   assign req_stall = stall_ff;

   // Stall is low exactly when the controller is idle
   a_stall_idle: assert property (@(posedge clock) disable iff (reset)
      req_stall == (state_ff != IDLE))
      else $error("stall out of step with controller state");

   // Every accepted transfer is decoded on the next cycle
   a_take_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.take_item |=> cmd.decode)
      else $error("accepted transfer not decoded");

   // At most one command is active in any cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one command active");

endmodule

`default_nettype wire

// ===== design/bounded_deque_engine_top.sv =====
// Top level of the bounded deque engine: controller and datapath.
// A status result is decoded from the accepted transfer and loaded into the result register;
// an emit reads the entry RAM and gives one element per cycle while rsp_stall is low.
// The block takes no new transfer until the current op is done; value removal walks every
// entry of the queue through the entry RAM, reading each and writing back the survivors.
// Reset (synchronous, active high) empties the queue; entry storage is not cleared.
`default_nettype none

module bounded_deque_engine_top #(
   parameter int unsigned CAPACITY = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [bde_pkg::OP_W-1:0]            req_opcode,
   input  wire logic signed [bde_pkg::DATA_W-1:0]   req_argument,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [bde_pkg::DATA_W-1:0]        rsp_item_value,
   output logic                                     rsp_item_valid,
   output logic                                     rsp_last_of_run,
   output logic [bde_pkg::STATUS_W-1:0]             rsp_status,
   output logic [bde_pkg::FILL_W-1:0]               rsp_fill_level
);

   bde_pkg::cmd_type cmd;
   bde_pkg::sts_type sts;

   bde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bde_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_opcode),
      .req_argument    (req_argument),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item_value  (rsp_item_value),
      .rsp_item_valid  (rsp_item_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_status      (rsp_status),
      .rsp_fill_level  (rsp_fill_level)
   );

endmodule

`default_nettype wire

// ===== dv/bounded_deque_engine_top_tb.sv =====
// Self-checking testbench for the bounded deque engine: directed and random ops, scoreboard.
`timescale 1ns / 1ps

module bounded_deque_engine_top_tb;

   localparam int DEPTH       = 32;
   localparam int LONG_HOLD   = 300;
   localparam int END_WAIT    = 40;
   localparam int CYCLE_LIMIT = 400000;

   typedef logic [bde_pkg::OP_W-1:0]          opcode_type;
   typedef logic signed [bde_pkg::DATA_W-1:0] value_type;

   typedef struct {
      opcode_type opcode;
      value_type  argument;
   } deque_op_type;

   typedef struct {
      value_type                    value;
      logic                         item_valid;
      logic                         last;
      logic [bde_pkg::STATUS_W-1:0] status;
      logic [bde_pkg::FILL_W-1:0]   fill;
   } deque_result_type;

   logic                         clock;
   logic                         reset        = 1'b1;
   logic                         req_valid    = 1'b0;
   logic                         req_stall;
   opcode_type                   req_opcode   = '0;
   value_type                    req_argument = '0;
   logic                         rsp_valid;
   logic                         rsp_stall    = 1'b0;
   value_type                    rsp_item_value;
   logic                         rsp_item_valid;
   logic                         rsp_last_of_run;
   logic [bde_pkg::STATUS_W-1:0] rsp_status;
   logic [bde_pkg::FILL_W-1:0]   rsp_fill_level;

   deque_op_type                 pending_ops[$];
   deque_result_type             awaited_results[$];

   // shadow deque
   value_type                    ring [DEPTH];
   int                           head = 0;
   int                           held = 0;

   int                           send_idle_pct = 0;
   int                           stall_pct     = 0;
   int                           hold_requests = 0;
   int                           failures      = 0;
   int                           cycle_count   = 0;

   bounded_deque_engine_top #(
      .CAPACITY(DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_argument   (req_argument),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item_value (rsp_item_value),
      .rsp_item_valid (rsp_item_valid),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_status     (rsp_status),
      .rsp_fill_level (rsp_fill_level)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int slot(input int k);
      return (head + k) % DEPTH;
   endfunction

   function automatic void await_result(input value_type value,
                                        input logic item_valid, input logic last,
                                        input logic [bde_pkg::STATUS_W-1:0] status);
      deque_result_type r;
      r.value      = value;
      r.item_valid = item_valid;
      r.last       = last;
      r.status     = status;
      r.fill       = held[bde_pkg::FILL_W-1:0];
      awaited_results.push_back(r);
   endfunction

   // Update the shadow deque for one accepted op and queue the results it causes.
   function automatic void apply_deque_op(input opcode_type op, input value_type arg);
      int n;
      int first;
      int kept;
      logic [bde_pkg::STATUS_W-1:0] st;
      value_type v;
      st = bde_pkg::ST_OK;
      if (op == bde_pkg::OP_EMIT_ALL || op == bde_pkg::OP_EMIT_FIRST ||
          op == bde_pkg::OP_EMIT_LAST) begin
         // negative counts act as zero, large ones clamp to the fill level
         n = (arg < 0) ? 0 : int'(arg);
         if (op == bde_pkg::OP_EMIT_ALL || n > held) n = held;
         first = (op == bde_pkg::OP_EMIT_LAST) ? held - n : 0;
         if (n == 0) begin
            await_result('0, 1'b0, 1'b1, bde_pkg::ST_OK);
         end else begin
            for (int r = 0; r < n; r++)
               await_result(ring[slot(first + r)], 1'b1, r == n - 1, bde_pkg::ST_OK);
         end
         return;
      end
      case (op)
         bde_pkg::OP_ADD_FRONT: begin
            if (held >= DEPTH) begin
               st = bde_pkg::ST_FULL;
            end else begin
               head = (head + DEPTH - 1) % DEPTH;
               ring[head] = arg;
               held++;
            end
         end
         bde_pkg::OP_ADD_BACK: begin
            if (held >= DEPTH) begin
               st = bde_pkg::ST_FULL;
            end else begin
               ring[slot(held)] = arg;
               held++;
            end
         end
         bde_pkg::OP_DROP_FRONT: begin
            if (held == 0) begin
               st = bde_pkg::ST_EMPTY;
            end else begin
               head = slot(1);
               held--;
            end
         end
         bde_pkg::OP_DROP_BACK: begin
            if (held == 0) st = bde_pkg::ST_EMPTY;
            else held--;
         end
         bde_pkg::OP_REMOVE: begin
            if (held == 0) begin
               st = bde_pkg::ST_EMPTY;
            end else begin
               // compact the survivors toward the front, keeping order
               kept = 0;
               for (int k = 0; k < held; k++) begin
                  v = ring[slot(k)];
                  if (v != arg) begin
                     ring[slot(kept)] = v;
                     kept++;
                  end
               end
               held = kept;
            end
         end
         bde_pkg::OP_CLEAR: begin
            head = 0;
            held = 0;
         end
         default: ;
      endcase
      await_result('0, 1'b0, 1'b1, st);
   endfunction

   task automatic check_field(input string field,
                              input logic signed [bde_pkg::DATA_W:0] want,
                              input logic signed [bde_pkg::DATA_W:0] got);
      if (got !== want) begin
         $error("field %s expected %0d got %0d", field, want, got);
         failures++;
      end
   endtask

   // Offer queued ops; predict on every transfer.
   always @(posedge clock) begin : drive_ops
      deque_op_type nxt;
      if (!reset) begin
         if (req_valid && !req_stall) apply_deque_op(req_opcode, req_argument);
         if (!req_valid || !req_stall) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_ops.pop_front();
               req_valid    <= 1'b1;
               req_opcode   <= nxt.opcode;
               req_argument <= nxt.argument;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Drive the result-side stall: random, or a long hold on request.
   always @(posedge clock) begin : drive_stall
      int holds_served;
      int hold_left;
      if (reset) begin
         holds_served = 0;
         hold_left    = 0;
         rsp_stall   <= 1'b0;
      end else begin
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Compare each result transfer with the oldest awaited result.
   always @(posedge clock) begin : check_results
      deque_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("result transfer with nothing awaited: item_value %0d", rsp_item_value);
            failures++;
         end else begin
            want = awaited_results.pop_front();
            check_field("item_value", want.value, rsp_item_value);
            check_field("item_valid", want.item_valid, rsp_item_valid);
            check_field("last_of_run", want.last, rsp_last_of_run);
            check_field("status", want.status, rsp_status);
            check_field("fill_level", want.fill, rsp_fill_level);
         end
      end
   end

   // Abort on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[bounded_deque_engine_top] ERROR");
         $finish;
      end
   end

   task automatic push_op(input opcode_type op, input value_type arg);
      deque_op_type item;
      item.opcode   = op;
      item.argument = arg;
      pending_ops.push_back(item);
   endtask

   // Values drawn often from a small pool so that removals find matches.
   function automatic value_type draw_entry_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -1;
         4, 5:    return $urandom_range(1, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic value_type draw_emit_count();
      case ($urandom_range(0, 7))
         0:       return $urandom | 32'h8000_0000;
         1:       return '0;
         2, 3:    return $urandom_range(1, 8);
         4:       return $urandom_range(9, 40);
         5:       return DEPTH;
         6:       return $urandom;
         default: return 32'sh7fff_ffff;
      endcase
   endfunction

   // Queue bursts of inserts and drops plus removals, emits and clears.
   task automatic queue_random_ops(input int target);
      int counted;
      int len;
      opcode_type op;
      counted = 0;
      while (counted < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               len = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
               repeat (len)
                  push_op($urandom_range(0, 1) ? bde_pkg::OP_ADD_BACK : bde_pkg::OP_ADD_FRONT,
                          draw_entry_value());
               counted += len;
            end
            3, 4: begin
               len = $urandom_range(1, 10);
               repeat (len)
                  push_op($urandom_range(0, 1) ? bde_pkg::OP_DROP_BACK
                                               : bde_pkg::OP_DROP_FRONT, $urandom);
               counted += len;
            end
            5: begin
               push_op(bde_pkg::OP_REMOVE, draw_entry_value());
               counted++;
            end
            6, 7: begin
               case ($urandom_range(0, 2))
                  0:       op = bde_pkg::OP_EMIT_ALL;
                  1:       op = bde_pkg::OP_EMIT_FIRST;
                  default: op = bde_pkg::OP_EMIT_LAST;
               endcase
               push_op(op, draw_emit_count());
               counted++;
            end
            8: begin
               // clear now and then; otherwise an opcode the block ignores
               if ($urandom_range(0, 1)) begin
                  push_op(bde_pkg::OP_CLEAR, $urandom);
                  counted++;
               end else begin
                  push_op(opcode_type'($urandom_range(bde_pkg::OP_CLEAR + 1,
                                                      {bde_pkg::OP_W{1'b1}})), $urandom);
               end
            end
            default: begin
               op = opcode_type'($urandom_range(bde_pkg::OP_ADD_FRONT, bde_pkg::OP_CLEAR));
               push_op(op, draw_entry_value());
               counted++;
            end
         endcase
      end
   endtask

   // Hold the sender until every transfer and awaited result is done.
   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_valid || awaited_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, every op, empty and clamp cases
      push_op(bde_pkg::OP_ADD_BACK, 32'sh8000_0000);
      push_op(bde_pkg::OP_ADD_FRONT, 32'sh7fff_ffff);
      push_op(bde_pkg::OP_ADD_BACK, 0);
      push_op(bde_pkg::OP_ADD_BACK, -1);
      push_op(bde_pkg::OP_ADD_FRONT, -1);
      push_op(bde_pkg::OP_EMIT_ALL, 0);
      push_op(bde_pkg::OP_EMIT_FIRST, 2);
      push_op(bde_pkg::OP_EMIT_LAST, 3);
      push_op(bde_pkg::OP_EMIT_FIRST, 32'sh8000_0000);
      push_op(bde_pkg::OP_EMIT_LAST, 0);
      push_op(bde_pkg::OP_EMIT_FIRST, 100);
      push_op(bde_pkg::OP_REMOVE, -1);
      push_op(bde_pkg::OP_REMOVE, 12345);
      push_op(bde_pkg::OP_EMIT_ALL, -7);
      push_op(bde_pkg::OP_DROP_FRONT, 0);
      push_op(bde_pkg::OP_DROP_BACK, 0);
      push_op(bde_pkg::OP_DROP_BACK, 0);
      push_op(bde_pkg::OP_DROP_BACK, 0);
      push_op(bde_pkg::OP_DROP_FRONT, 0);
      push_op(bde_pkg::OP_REMOVE, 0);
      push_op(bde_pkg::OP_EMIT_LAST, 5);
      push_op(opcode_type'(bde_pkg::OP_CLEAR + 1), 32'sh7fff_ffff);
      push_op({bde_pkg::OP_W{1'b1}}, -1);
      push_op(bde_pkg::OP_ADD_FRONT, 5);
      push_op(bde_pkg::OP_CLEAR, 0);
      push_op(bde_pkg::OP_EMIT_ALL, 0);
      wait_drained();

      // no idling; fill past capacity under a long receiver hold
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (34)
         push_op($urandom_range(0, 1) ? bde_pkg::OP_ADD_BACK : bde_pkg::OP_ADD_FRONT,
                 $urandom);
      queue_random_ops(50);
      hold_requests++;
      wait_drained();

      send_idle_pct = 58;
      stall_pct     = 0;
      queue_random_ops(88);
      wait_drained();

      send_idle_pct = 0;
      stall_pct     = 58;
      queue_random_ops(88);
      wait_drained();

      send_idle_pct = 17;
      stall_pct     = 17;
      queue_random_ops(88);
      wait_drained();

      repeat (END_WAIT) @(posedge clock);
      if (failures == 0) begin
         $display("[bounded_deque_engine_top] OK");
      end else begin
         $display("[bounded_deque_engine_top] ERROR");
      end
      $finish;
   end

endmodule
